// File: hw/rtl/psgn_pkg.sv
// Package for the PSG register write and noise block.
// Holds field widths, command codes, the volume table and the shared control types.
// Used by every module under hw/rtl except psgn_alu; it depends on nothing.
`default_nettype none

package psgn_pkg;

  localparam int unsigned STEP_W   = 16;
  localparam int unsigned PERIOD_W = 12;
  localparam int unsigned ADD_W    = STEP_W + 3;
  localparam int unsigned LEVEL_W  = 14;
  localparam int unsigned LFSR_W   = 17;
  localparam int unsigned DIV_CNT_W = $clog2(STEP_W);

  localparam int unsigned ADD_MAX = ((1 << STEP_W) - 1) << 3;
  localparam int unsigned PHASE_UNIT_DEF = 1024;

  localparam logic [STEP_W-1:0] STEP_RESET = 16'd2597;

  localparam logic [1:0] CMD_PSG_WRITE = 2'd0;
  localparam logic [1:0] CMD_STEREO    = 2'd1;
  localparam logic [1:0] CMD_TICK      = 2'd2;

  localparam logic [7:0] LATCH_MASK  = 8'h90;
  localparam logic [7:0] LATCH_CODE  = 8'h80;
  localparam logic [7:0] VOLUME_CODE = 8'h90;
  localparam logic [1:0] CH_TONE2    = 2'd2;
  localparam logic [1:0] CH_NOISE    = 2'd3;
  localparam logic [1:0] RATE_FROM_TONE2 = 2'd3;

  localparam logic [LFSR_W-1:0] LFSR_SEED         = 17'h00001;
  localparam logic [LFSR_W-1:0] LFSR_TAP_WHITE    = 17'h12000;
  localparam logic [LFSR_W-1:0] LFSR_TAP_PERIODIC = 17'h10000;

  typedef struct packed {
    logic [PERIOD_W-1:0] period2;
    logic [2:0]          noise_ctl;
    logic [3:0]          volume;
    logic                cut_left;
    logic                cut_right;
  } psgn_ctl_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] left;
    logic [LEVEL_W-1:0] right;
  } psgn_res_t;

  function automatic logic [8:0] vol_lookup(input logic [3:0] idx);
    logic [8:0] v;
    unique case (idx)
      4'd0:  v = 9'h000;
      4'd1:  v = 9'h011;
      4'd2:  v = 9'h017;
      4'd3:  v = 9'h01d;
      4'd4:  v = 9'h028;
      4'd5:  v = 9'h031;
      4'd6:  v = 9'h03a;
      4'd7:  v = 9'h04b;
      4'd8:  v = 9'h060;
      4'd9:  v = 9'h074;
      4'd10: v = 9'h094;
      4'd11: v = 9'h0bd;
      4'd12: v = 9'h0e0;
      4'd13: v = 9'h0fc;
      4'd14: v = 9'h0ff;
      default: v = 9'h100;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/psgn_alu.sv
// Shared add/subtract unit of the noise sequencer.
// Serves divide steps, the phase add and the phase-unit compare; it does not use psgn_pkg.
`default_nettype none

module psgn_alu #(
  parameter int unsigned W = 20
) (
  input  wire logic [W-1:0] a_i,
  input  wire logic [W-1:0] b_i,
  input  wire logic         sub_i,
  output logic      [W-1:0] sum_o,
  output logic              carry_o
);

  logic [W:0] full;

  // With subtraction the carry out is set exactly when a is not below b.
  assign full = {1'b0, a_i} + {1'b0, b_i ^ {W{sub_i}}} + (W+1)'(sub_i);
  assign sum_o   = full[W-1:0];
  assign carry_o = full[W];

endmodule

`default_nettype wire

// File: hw/rtl/psgn_decode.sv
// PSG byte decoder: channel 2 period, noise control, noise volume and stereo cuts.
// Depends on psgn_pkg for the command constants and the control struct.
`default_nettype none

module psgn_decode
  import psgn_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       psg_we_i,
  input  wire logic       stereo_we_i,
  input  wire logic [7:0] data_i,
  output psgn_ctl_t       ctl_o,
  output logic            reseed_o
);

  logic [PERIOD_W-1:0] period2_q, period2_d;
  logic [2:0]          noise_ctl_q, noise_ctl_d;
  logic [3:0]          volume_q, volume_d;
  logic [7:0]          prev_q, prev_d;
  logic                cut_left_q, cut_left_d;
  logic                cut_right_q, cut_right_d;
  logic                prev_latch, data_latch, data_volume;
  logic [1:0]          prev_ch, data_ch;

  assign prev_latch  = (prev_q & LATCH_MASK) == LATCH_CODE;
  assign data_latch  = (data_i & LATCH_MASK) == LATCH_CODE;
  assign data_volume = (data_i & LATCH_MASK) == VOLUME_CODE;
  assign prev_ch     = prev_q[6:5];
  assign data_ch     = data_i[6:5];

  // Only channel 2 (divider source) and the low bits of channel 3 (rate and
  // mode) affect the noise output, so the other period bits are not kept.
  always_comb begin
    period2_d   = period2_q;
    noise_ctl_d = noise_ctl_q;
    volume_d    = volume_q;
    prev_d      = prev_q;
    cut_left_d  = cut_left_q;
    cut_right_d = cut_right_q;
    reseed_o    = 1'b0;
    if (psg_we_i) begin
      if (prev_latch && prev_ch == CH_TONE2) begin
        period2_d[PERIOD_W-1:4] = data_i;
      end
      if (data_latch && data_ch == CH_TONE2) begin
        period2_d[3:0] = data_i[3:0];
      end
      if (data_latch && data_ch == CH_NOISE) begin
        noise_ctl_d = data_i[2:0];
        reseed_o    = 1'b1;
      end
      if (data_volume && data_ch == CH_NOISE) begin
        volume_d = ~data_i[3:0];
      end
      prev_d = data_i;
    end
    if (stereo_we_i) begin
      cut_left_d  = ~data_i[7];
      cut_right_d = ~data_i[3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period2_q   <= '0;
      noise_ctl_q <= '0;
      volume_q    <= '0;
      prev_q      <= '0;
      cut_left_q  <= 1'b0;
      cut_right_q <= 1'b0;
    end else begin
      period2_q   <= period2_d;
      noise_ctl_q <= noise_ctl_d;
      volume_q    <= volume_d;
      prev_q      <= prev_d;
      cut_left_q  <= cut_left_d;
      cut_right_q <= cut_right_d;
    end
  end

  assign ctl_o.period2   = period2_q;
  assign ctl_o.noise_ctl = noise_ctl_q;
  assign ctl_o.volume    = volume_q;
  assign ctl_o.cut_left  = cut_left_q;
  assign ctl_o.cut_right = cut_right_q;

endmodule

`default_nettype wire

// File: hw/rtl/psgn_noise_seq.sv
// Noise sequencer: output level, phase advance with an optional divide, LFSR stepping.
// Depends on psgn_pkg and instantiates psgn_alu as its only arithmetic unit.
`default_nettype none

module psgn_noise_seq
  import psgn_pkg::*;
#(
  parameter int unsigned PHASE_UNIT = PHASE_UNIT_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire psgn_ctl_t         ctl_i,
  input  wire logic [STEP_W-1:0] step_inc_i,
  input  wire logic              start_i,
  input  wire logic              reseed_i,
  input  wire logic              emit_ready_i,
  output logic                   idle_o,
  output logic                   emit_o,
  output psgn_res_t              res_o
);

  localparam int unsigned PHASE_W = $clog2(PHASE_UNIT + ADD_MAX);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_ADD,
    S_STEP,
    S_EMIT
  } state_e;

  state_e               state_q, state_d;
  logic [LFSR_W-1:0]    lfsr_q, lfsr_d;
  logic [PHASE_W-1:0]   phase_q, phase_d;
  logic [ADD_W-1:0]     acc_q, acc_d;
  logic [PERIOD_W-1:0]  rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  psgn_res_t            res_q, res_d;

  logic [PHASE_W-1:0]   alu_a, alu_b, alu_sum;
  logic                 alu_sub, alu_carry;
  logic [PERIOD_W:0]    trial;
  logic [1:0]           rate;
  logic [1:0]           shift;
  logic [LEVEL_W-1:0]   vol, level;
  logic [LFSR_W-1:0]    tapped;

  psgn_alu #(
    .W (PHASE_W)
  ) u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sub_i   (alu_sub),
    .sum_o   (alu_sum),
    .carry_o (alu_carry)
  );

  assign trial = {rem_q, acc_q[STEP_W-1]};
  assign rate  = ctl_i.noise_ctl[1:0];
  assign shift = (rate == RATE_FROM_TONE2) ? 2'd3 : ~rate;
  assign vol   = {1'b0, vol_lookup(ctl_i.volume), 4'b0000};
  assign level = lfsr_q[0] ? vol : -vol;
  assign tapped = lfsr_q ^ ({LFSR_W{lfsr_q[0]}} &
                  (ctl_i.noise_ctl[2] ? LFSR_TAP_WHITE : LFSR_TAP_PERIODIC));

  always_comb begin
    alu_a   = phase_q;
    alu_b   = PHASE_W'(PHASE_UNIT);
    alu_sub = 1'b1;
    unique case (state_q)
      S_DIV: begin
        alu_a = PHASE_W'(trial);
        alu_b = PHASE_W'(ctl_i.period2);
      end
      S_ADD: begin
        alu_b   = PHASE_W'(acc_q);
        alu_sub = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    lfsr_d  = lfsr_q;
    phase_d = phase_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (reseed_i) begin
          lfsr_d = LFSR_SEED;
        end
        if (start_i) begin
          // The result uses the LFSR as it stands before this tick's steps.
          res_d.level = level;
          res_d.left  = ctl_i.cut_left  ? LEVEL_W'($signed(level) >>> 2) : level;
          res_d.right = ctl_i.cut_right ? LEVEL_W'($signed(level) >>> 2) : level;
          rem_d = '0;
          cnt_d = '0;
          if (rate == RATE_FROM_TONE2 && ctl_i.period2 != '0) begin
            acc_d   = ADD_W'(step_inc_i);
            state_d = S_DIV;
          end else begin
            acc_d   = ADD_W'(step_inc_i) << shift;
            state_d = S_ADD;
          end
        end
      end
      S_DIV: begin
        // Restoring divide, one quotient bit per cycle.
        rem_d = alu_carry ? alu_sum[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
        acc_d = {acc_q[ADD_W-1:STEP_W], acc_q[STEP_W-2:0], alu_carry};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(STEP_W - 1)) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        phase_d = alu_sum;
        state_d = S_STEP;
      end
      S_STEP: begin
        if (alu_carry) begin
          phase_d = alu_sum;
          lfsr_d  = {1'b0, tapped[LFSR_W-1:1]};
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lfsr_q  <= LFSR_SEED;
      phase_q <= '0;
      acc_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      lfsr_q  <= lfsr_d;
      phase_q <= phase_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
      res_q   <= res_d;
    end
  end

  assign idle_o = state_q == S_IDLE;
  assign emit_o = state_q == S_EMIT;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  // The feedback only reaches the top bit just before a shift, so it is
  // always clear between edges and the register can never lock up at zero.
  a_lfsr_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfsr_q != '0 && !lfsr_q[LFSR_W-1])
    else $error("noise LFSR reached an illegal value");

  a_phase_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT || state_q == S_IDLE) |-> phase_q < PHASE_W'(PHASE_UNIT))
    else $error("noise phase left at or above one unit after a tick");

  a_div_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < ctl_i.period2)
    else $error("divider remainder not below the divisor");

  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && $past(state_q) == S_IDLE) |-> cnt_q == '0)
    else $error("divide started with a stale step count");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/psg_register_write_and_noise.sv
// Top level of the PSG register write and noise block: handshakes, step register, output register.
// Depends on psgn_pkg, psgn_decode and psgn_noise_seq (which holds psgn_alu).
//
//   channel | signals                                                          | direction
//   --------+------------------------------------------------------------------+----------
//   in      | in_valid_i, in_ready_o, cmd_i, data_i                            | input
//   out     | out_valid_o, out_ready_i, noise_level_o, left_out_o, right_out_o | output
//   cfg     | cfg_valid_i, cfg_ready_o, cfg_data_i                             | input
//
// Byte and stereo writes are taken while the sequencer is idle. A tick runs the divide when
// the rate comes from channel 2 with a nonzero period, then the phase add, one LFSR step per
// whole PHASE_UNIT of phase and the emit, with the one shared adder/subtractor. Reset
// clears decoder state, sets step to STEP_RESET, reseeds the LFSR; no clearing pass is needed.
// A finished result waits in the output register while the next items are taken;
// a second result stalls the sequencer until that register is free.
`default_nettype none

module psg_register_write_and_noise
  import psgn_pkg::*;
#(
  parameter int unsigned PHASE_UNIT = PHASE_UNIT_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [1:0]                cmd_i,
  input  wire logic [7:0]                data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic signed [LEVEL_W-1:0]      noise_level_o,
  output logic signed [LEVEL_W-1:0]      left_out_o,
  output logic signed [LEVEL_W-1:0]      right_out_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [STEP_W-1:0]         cfg_data_i
);

  logic [STEP_W-1:0] step_q;
  logic              in_xfer, seq_idle, seq_emit, emit_ready;
  psgn_ctl_t         ctl;
  logic              reseed;
  psgn_res_t         seq_res, out_q;
  logic              out_valid_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = seq_idle;
  assign in_xfer     = in_valid_i && seq_idle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_RESET;
    end else if (cfg_valid_i) begin
      step_q <= cfg_data_i;
    end
  end

  psgn_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psg_we_i    (in_xfer && cmd_i == CMD_PSG_WRITE),
    .stereo_we_i (in_xfer && cmd_i == CMD_STEREO),
    .data_i      (data_i),
    .ctl_o       (ctl),
    .reseed_o    (reseed)
  );

  psgn_noise_seq #(
    .PHASE_UNIT (PHASE_UNIT)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .step_inc_i   (step_q),
    .start_i      (in_xfer && cmd_i == CMD_TICK),
    .reseed_i     (reseed),
    .emit_ready_i (emit_ready),
    .idle_o       (seq_idle),
    .emit_o       (seq_emit),
    .res_o        (seq_res)
  );

  assign emit_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_ready) begin
      out_valid_q <= seq_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ready && seq_emit) begin
      out_q <= seq_res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign noise_level_o = $signed(out_q.level);
  assign left_out_o    = $signed(out_q.left);
  assign right_out_o   = $signed(out_q.right);

endmodule

`default_nettype wire

// File: test/tb_psg_register_write_and_noise.sv
// Self-checking testbench for psg_register_write_and_noise: PSG byte decode, stereo cut,
// noise level and LFSR stepping, checked against a predictor kept inside this module.
// Depends on psgn_pkg and the psg_register_write_and_noise top level.
module tb_psg_register_write_and_noise;
  timeunit 1ns;
  timeprecision 1ps;
  import psgn_pkg::*;

  localparam int unsigned PHASE_UNIT    = PHASE_UNIT_DEF;
  localparam int unsigned CYCLE_LIMIT   = 5_000_000;
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned IDLE_PCT      = 36;
  localparam int unsigned PHASE_ITEMS   = 210;
  localparam int unsigned FAST_ITEMS    = 40;
  localparam int unsigned STALL_CYCLES  = 400;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  logic [1:0]                cmd_i       = CMD_TICK;
  logic [7:0]                data_i      = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [LEVEL_W-1:0] noise_level_o;
  logic signed [LEVEL_W-1:0] left_out_o;
  logic signed [LEVEL_W-1:0] right_out_o;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [STEP_W-1:0]         cfg_data_i  = STEP_RESET;

  psg_register_write_and_noise #(
    .PHASE_UNIT(PHASE_UNIT)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .data_i       (data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .noise_level_o(noise_level_o),
    .left_out_o   (left_out_o),
    .right_out_o  (right_out_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  // Predictor state.
  logic [PERIOD_W-1:0] tone_period [4];
  logic [3:0]          noise_atten;
  logic [7:0]          last_psg_byte;
  logic [7:0]          stereo_cut;
  logic [LFSR_W-1:0]   noise_lfsr;
  int unsigned         noise_acc;
  logic [STEP_W-1:0]   step_reg;
  logic [8:0]          vol_steps [16] = '{
    9'h000, 9'h011, 9'h017, 9'h01d, 9'h028, 9'h031, 9'h03a, 9'h04b,
    9'h060, 9'h074, 9'h094, 9'h0bd, 9'h0e0, 9'h0fc, 9'h0ff, 9'h100
  };
  psgn_res_t           mix_expected [$];

  int unsigned items_sent      = 0;
  int unsigned ticks_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned step_writes     = 0;
  int unsigned cycles          = 0;
  bit          steady          = 1'b0;
  int unsigned hold_request    = 0;
  int unsigned hold_left       = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycles, mix_expected.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic reset_model();
    foreach (tone_period[i]) tone_period[i] = '0;
    noise_atten   = '0;
    last_psg_byte = '0;
    stereo_cut    = '0;
    noise_lfsr    = LFSR_SEED;
    noise_acc     = 0;
    step_reg      = STEP_RESET;
  endtask

  task automatic predict_mix(input logic [1:0] op, input logic [7:0] d);
    logic [1:0]                ch;
    logic signed [LEVEL_W-1:0] lvl;
    int unsigned               add;
    int unsigned               sel;
    psgn_res_t                 r;
    case (op)
      CMD_PSG_WRITE: begin
        // Whatever follows a latch byte lands in the high bits of that channel.
        if ((last_psg_byte & LATCH_MASK) == LATCH_CODE) begin
          ch = last_psg_byte[6:5];
          tone_period[ch][11:4] = d;
        end
        if ((d & LATCH_MASK) == LATCH_CODE) begin
          ch = d[6:5];
          tone_period[ch][3:0] = d[3:0];
          if (ch == CH_NOISE) noise_lfsr = LFSR_SEED;
        end
        if ((d & LATCH_MASK) == VOLUME_CODE && d[6:5] == CH_NOISE) noise_atten = ~d[3:0];
        last_psg_byte = d;
      end
      CMD_STEREO: stereo_cut = ~d;
      CMD_TICK: begin
        // The outputs use the LFSR as it stands before this tick advances it.
        lvl = LEVEL_W'({vol_steps[noise_atten], 4'b0000});
        if (!noise_lfsr[0]) lvl = -lvl;
        sel = tone_period[CH_NOISE][1:0];
        if (sel == RATE_FROM_TONE2) begin
          if (tone_period[CH_TONE2] != '0) add = 32'(step_reg) / 32'(tone_period[CH_TONE2]);
          else add = 32'(step_reg) << 3;
        end else begin
          add = 32'(step_reg) << (3 - sel);
        end
        noise_acc += add;
        while (noise_acc >= PHASE_UNIT) begin
          if (noise_lfsr[0]) begin
            noise_lfsr ^= tone_period[CH_NOISE][2] ? LFSR_TAP_WHITE : LFSR_TAP_PERIODIC;
          end
          noise_lfsr = noise_lfsr >> 1;
          noise_acc -= PHASE_UNIT;
        end
        r.level = lvl;
        r.left  = stereo_cut[7] ? lvl >>> 2 : lvl;
        r.right = stereo_cut[3] ? lvl >>> 2 : lvl;
        mix_expected.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic send_command(input logic [1:0] op, input logic [7:0] d);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= op;
    data_i     <= d;
    do @(posedge clk_i); while (!in_ready_o);
    predict_mix(op, d);
    items_sent++;
    if (op == CMD_TICK) ticks_sent++;
  endtask

  task automatic wait_for_results();
    while (mix_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_step(input logic [STEP_W-1:0] v);
    in_valid_i <= 1'b0;
    wait_for_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    step_reg = v;
    step_writes++;
  endtask

  // Receiver: random back-pressure, or a long hold-off when a test asks for one.
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin : check_mix
    psgn_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (mix_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: level %0d left %0d right %0d",
                   noise_level_o, left_out_o, right_out_o);
        end
      end else begin
        want = mix_expected.pop_front();
        results_checked++;
        if (noise_level_o !== want.level || left_out_o !== want.left ||
            right_out_o !== want.right) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: expected level %0d left %0d right %0d, got %0d %0d %0d",
                     results_checked, $signed(want.level), $signed(want.left),
                     $signed(want.right), noise_level_o, left_out_o, right_out_o);
          end
        end
      end
    end
  end

  task automatic test_reset_state();
    // Volume resets to zero, so the first tick is silent.
    send_command(CMD_TICK, 8'h00);
  endtask

  task automatic test_noise_volume();
    send_command(CMD_PSG_WRITE, 8'hF0);
    send_command(CMD_TICK, 8'hFF);
    // A tone volume write must leave the noise volume alone.
    send_command(CMD_PSG_WRITE, 8'hB5);
    send_command(CMD_TICK, 8'h00);
  endtask

  task automatic test_stereo_cut();
    send_command(CMD_STEREO, 8'h7F);
    send_command(CMD_TICK, 8'h55);
    send_command(CMD_STEREO, 8'hF7);
    send_command(CMD_TICK, 8'hAA);
    send_command(CMD_STEREO, 8'h00);
    send_command(CMD_TICK, 8'h00);
  endtask

  task automatic test_pitch_writes();
    send_command(CMD_PSG_WRITE, 8'hC5);
    send_command(CMD_PSG_WRITE, 8'h3F);
    send_command(CMD_PSG_WRITE, 8'hE7);
    send_command(CMD_TICK, 8'h00);
    // A latch right after a latch is both the high byte and a new latch.
    send_command(CMD_PSG_WRITE, 8'h8A);
    send_command(CMD_PSG_WRITE, 8'hE0);
    send_command(CMD_TICK, 8'h00);
    // Rate taken from channel 2 while its period is zero.
    send_command(CMD_PSG_WRITE, 8'hC0);
    send_command(CMD_PSG_WRITE, 8'h00);
    send_command(CMD_PSG_WRITE, 8'hE7);
    send_command(CMD_TICK, 8'h00);
  endtask

  task automatic test_step_register();
    write_step(16'h0000);
    send_command(CMD_TICK, 8'h00);
    send_command(CMD_TICK, 8'h00);
    write_step(16'hFFFF);
    send_command(CMD_TICK, 8'h00);
    send_command(CMD_PSG_WRITE, 8'hE4);
    send_command(CMD_TICK, 8'h00);
    write_step(16'h0001);
    send_command(CMD_TICK, 8'h00);
    write_step(STEP_RESET);
  endtask

  task automatic test_output_stall();
    // Hold the output side off while ticks keep coming, so the block backs up.
    hold_request = STALL_CYCLES;
    steady = 1'b1;
    repeat (24) send_command(CMD_TICK, 8'($urandom));
    steady = 1'b0;
    in_valid_i <= 1'b0;
    wait_for_results();
  endtask

  task automatic send_random_traffic_item();
    int unsigned pick;
    logic [1:0]  ch;
    pick = $urandom_range(99);
    ch   = 2'($urandom_range(3));
    if (pick < 45) begin
      send_command(CMD_TICK, 8'($urandom));
    end else if (pick < 62) begin
      send_command(CMD_PSG_WRITE, {1'b1, ch, 1'b0, 4'($urandom)});
      // Mostly a clean data byte; now and then any byte follows the latch.
      send_command(CMD_PSG_WRITE,
                   ($urandom_range(3) == 0) ? 8'($urandom) : {2'b00, 6'($urandom)});
    end else if (pick < 74) begin
      if ($urandom_range(2) != 0) ch = CH_NOISE;
      send_command(CMD_PSG_WRITE, {1'b1, ch, 1'b1, 4'($urandom)});
    end else if (pick < 84) begin
      send_command(CMD_STEREO, 8'($urandom));
    end else begin
      send_command(CMD_PSG_WRITE, 8'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    int unsigned target;
    for (int p = 0; p < 8; p++) begin
      target = items_sent + PHASE_ITEMS;
      case (p)
        0: ;
        3: begin
          write_step(16'hFFFF);
          target = items_sent + FAST_ITEMS;
        end
        5: write_step(16'h0000);
        default: write_step(16'($urandom_range(6000)));
      endcase
      steady = (p == 2);
      while (items_sent < target) send_random_traffic_item();
      steady = 1'b0;
    end
  endtask

  initial begin
    reset_model();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_noise_volume();
    test_stereo_cut();
    test_pitch_writes();
    test_step_register();
    test_output_stall();
    test_random_traffic();
    in_valid_i <= 1'b0;
    wait_for_results();
    $display("Sent %0d items (%0d ticks) over %0d step settings in %0d cycles.",
             items_sent, ticks_sent, step_writes, cycles);
    $display("Checked %0d noise mix results, %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0 && mix_expected.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: psg_register_write_and_noise.f
hw/rtl/psgn_pkg.sv
hw/rtl/psgn_alu.sv
hw/rtl/psgn_decode.sv
hw/rtl/psgn_noise_seq.sv
hw/rtl/psg_register_write_and_noise.sv
test/tb_psg_register_write_and_noise.sv
